// ===== hdl/lcd_spi_command_sequencer_assert.svh =====
// Assertion macros for the LCD SPI command sequencer.
// Included by the top level; no other dependencies.
`ifndef LCD_SPI_COMMAND_SEQUENCER_ASSERT_SVH
`define LCD_SPI_COMMAND_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define LCDSEQ_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("lcdseq assertion failed");
// Condition in one cycle implies a consequence in the next
`define LCDSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lcdseq assertion failed");
`else
`define LCDSEQ_ASSERT(label, clk, rstn, prop)
`define LCDSEQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/lcdseq_pkg.sv =====
// Shared types, command codes and the byte sequence table of the LCD sequencer.
// No dependencies.
package lcdseq_pkg;

  // Input operation codes
  typedef enum logic [2:0] {
    OP_BEGIN    = 3'd0,
    OP_INVERSE  = 3'd1,
    OP_CONTRAST = 3'd2,
    OP_POWER    = 3'd3,
    OP_ROW      = 3'd4,
    OP_PIXEL    = 3'd5
  } op_e;

  // Configuration register indexes
  localparam logic CFG_STARTUP_CONTRAST = 1'b0;
  localparam logic CFG_PANEL_VARIANT    = 1'b1;

  localparam logic [7:0] CONTRAST_RESET = 8'd15;

  // Controller command bytes
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
  localparam logic [7:0] CMD_COL_LOW     = 8'h04;
  localparam logic [7:0] CMD_SYS_RESET   = 8'hE2;
  localparam logic [7:0] CMD_POWER_CTRL  = 8'h2F;
  localparam logic [7:0] CMD_VOLUME      = 8'h81;
  localparam logic [7:0] CMD_BIAS        = 8'hA2;
  localparam logic [7:0] CMD_SEG_NORMAL  = 8'hA0;
  localparam logic [7:0] CMD_SEG_REVERSE = 8'hA1;
  localparam logic [7:0] CMD_COM_NORMAL  = 8'hC0;
  localparam logic [7:0] CMD_COM_REVERSE = 8'hC8;
  localparam logic [7:0] CMD_VIDEO_INV   = 8'hA7;
  localparam logic [7:0] CMD_VIDEO_NORM  = 8'hA4;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] CMD_ALL_ON      = 8'hA5;

  localparam int unsigned IDX_W = 4;  // begin has nine bytes

  // Byte sequences the back end knows how to play
  typedef enum logic [2:0] {
    SEQ_BEGIN,
    SEQ_VIDEO,
    SEQ_CONTRAST,
    SEQ_SLEEP,
    SEQ_ROW,
    SEQ_PIXEL
  } seq_e;

  // One queued job: which sequence plus its operands
  typedef struct packed {
    seq_e       kind;
    logic [7:0] value;    // contrast for begin, contrast, page, pixel byte
    logic       flag;     // video inverted
    logic       variant;  // panel variant captured at accept
  } desc_t;

  // One link byte with its flags
  typedef struct packed {
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;
  } byte_t;

  // Back end status toward the top level
  typedef struct packed {
    logic             emit;
    logic             pop;
    logic             last;
    logic [IDX_W-1:0] idx;
  } back_stat_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] video_cmd(input logic inv);
    return inv ? CMD_VIDEO_INV : CMD_VIDEO_NORM;
  endfunction

  // Byte number idx of the sequence described by d
  function automatic byte_t seq_byte(input desc_t d, input logic [IDX_W-1:0] idx);
    byte_t b;
    b.link_byte = CMD_DISPLAY_ON;
    b.is_data   = 1'b0;
    b.last      = 1'b1;
    unique case (d.kind)
      SEQ_BEGIN: begin
        b.last = (idx >= IDX_W'(8));
        unique case (idx)
          IDX_W'(0): b.link_byte = CMD_SYS_RESET;
          IDX_W'(1): b.link_byte = CMD_POWER_CTRL;
          IDX_W'(2): b.link_byte = CMD_VOLUME;
          IDX_W'(3): b.link_byte = d.value;
          IDX_W'(4): b.link_byte = CMD_BIAS;
          IDX_W'(5): b.link_byte = d.variant ? CMD_SEG_NORMAL : CMD_SEG_REVERSE;
          IDX_W'(6): b.link_byte = d.variant ? CMD_COM_REVERSE : CMD_COM_NORMAL;
          IDX_W'(7): b.link_byte = video_cmd(d.flag);
          default:   b.link_byte = CMD_DISPLAY_ON;
        endcase
      end
      SEQ_VIDEO: begin
        b.last      = (idx != '0);
        b.link_byte = (idx == '0) ? video_cmd(d.flag) : CMD_DISPLAY_ON;
      end
      SEQ_CONTRAST: begin
        b.last      = (idx != '0);
        b.link_byte = (idx == '0) ? CMD_VOLUME : d.value;
      end
      SEQ_SLEEP: begin
        b.last      = (idx != '0);
        b.link_byte = (idx == '0) ? CMD_DISPLAY_OFF : CMD_ALL_ON;
      end
      SEQ_ROW: begin
        if (idx == '0) begin
          b.last      = 1'b0;
          b.link_byte = CMD_PAGE_BASE | {4'h0, d.value[3:0]};
        end else if (idx == IDX_W'(1)) begin
          b.last      = d.variant;
          b.link_byte = CMD_COL_HIGH;
        end else begin
          b.last      = 1'b1;
          b.link_byte = CMD_COL_LOW;
        end
      end
      SEQ_PIXEL: begin
        b.last      = 1'b1;
        b.is_data   = 1'b1;
        b.link_byte = d.value;
      end
      default: begin
        b.last = 1'b1;
      end
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcdseq_front.sv =====
// Front end: accepts items, holds configuration and display state, and
// queues a job for each item that sends bytes. Depends on lcdseq_pkg.
module lcdseq_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           operation_i,
  input  logic [7:0]           value_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output lcdseq_pkg::desc_t    desc_o
);

  logic [7:0] contrast_q;
  logic       variant_q;
  logic       awake_q, awake_d;
  logic       inv_q, inv_d;
  logic       accept;
  logic       flag;
  logic       emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign flag       = (value_i != 8'h00);
  assign push_o     = accept && emit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q <= lcdseq_pkg::CONTRAST_RESET;
      variant_q  <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lcdseq_pkg::CFG_STARTUP_CONTRAST) begin
        contrast_q <= cfg_data_i;
      end else begin
        variant_q <= cfg_data_i[0];
      end
    end
  end

  // Classify the item and work out the state it leaves
  always_comb begin
    awake_d        = awake_q;
    inv_d          = inv_q;
    emit           = 1'b1;
    desc_o.kind    = lcdseq_pkg::SEQ_PIXEL;
    desc_o.value   = value_i;
    desc_o.flag    = flag;
    desc_o.variant = variant_q;
    unique case (lcdseq_pkg::op_e'(operation_i))
      lcdseq_pkg::OP_BEGIN: begin
        desc_o.kind  = lcdseq_pkg::SEQ_BEGIN;
        desc_o.value = contrast_q;
      end
      lcdseq_pkg::OP_INVERSE: begin
        desc_o.kind = lcdseq_pkg::SEQ_VIDEO;
        inv_d       = flag;
      end
      lcdseq_pkg::OP_CONTRAST: begin
        desc_o.kind = lcdseq_pkg::SEQ_CONTRAST;
      end
      lcdseq_pkg::OP_POWER: begin
        // unchanged power state sends nothing
        emit        = (flag != awake_q);
        awake_d     = flag;
        desc_o.kind = flag ? lcdseq_pkg::SEQ_VIDEO : lcdseq_pkg::SEQ_SLEEP;
        desc_o.flag = inv_q;
      end
      lcdseq_pkg::OP_ROW: begin
        desc_o.kind = lcdseq_pkg::SEQ_ROW;
      end
      lcdseq_pkg::OP_PIXEL: begin
        desc_o.kind = lcdseq_pkg::SEQ_PIXEL;
      end
      default: begin
        emit = 1'b0;  // unused codes are dropped
      end
    endcase
  end

  // Display state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awake_q <= 1'b1;
      inv_q   <= 1'b0;
    end else if (accept) begin
      awake_q <= awake_d;
      inv_q   <= inv_d;
    end
  end

endmodule

// ===== hdl/lcdseq_fifo.sv =====
// Short job queue between front and back end.
// Depends on lcdseq_pkg.
module lcdseq_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcdseq_pkg::desc_t    push_data_i,
  input  logic                 pop_i,
  output lcdseq_pkg::desc_t    head_o,
  output lcdseq_pkg::q_stat_t  stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lcdseq_pkg::desc_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lcdseq_back.sv =====
// Back end: steps through the job at the queue head and hands its bytes to
// the output register, one per cycle unless stalled. Depends on lcdseq_pkg.
module lcdseq_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcdseq_pkg::desc_t      head_i,
  input  logic                   head_valid_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             link_byte_o,
  output logic                   is_data_o,
  output logic                   last_o,
  output lcdseq_pkg::back_stat_t stat_o
);

  logic [lcdseq_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                         out_valid_q, out_valid_d;
  lcdseq_pkg::byte_t            cur;
  lcdseq_pkg::byte_t            out_q;
  logic                         emit;

  assign cur  = lcdseq_pkg::seq_byte(head_i, idx_q);
  assign emit = head_valid_i && (!out_valid_q || out_ready_i);

  // Byte counter and output handshake
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = cur.last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign link_byte_o = out_q.link_byte;
  assign is_data_o   = out_q.is_data;
  assign last_o      = out_q.last;

  assign stat_o.emit = emit;
  assign stat_o.pop  = emit && cur.last;
  assign stat_o.last = cur.last;
  assign stat_o.idx  = idx_q;

endmodule

// ===== hdl/lcd_spi_command_sequencer.sv =====
// LCD SPI command sequencer: turns display operations into command and data
// bytes for a write-only serial LCD link. The front end takes one item per
// cycle as long as the job queue (QUEUE_DEPTH entries) has room; state
// updates and the choice of byte sequence happen at accept. The back end
// delivers one link byte per cycle while the output is taken. An item
// yields 9 bytes for begin, 2 or 3 for the others, 1 for a pixel byte;
// power items that change nothing and unused codes cost no back end time.
// The output register is refilled in the cycle its byte is taken, so bytes
// follow with no gap; while a byte waits the back end holds. Configuration
// is read at accept. Depends on lcdseq_pkg, the front, queue and back
// modules, and the assertion macro header.
`include "lcd_spi_command_sequencer_assert.svh"

module lcd_spi_command_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [7:0] value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] link_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  lcdseq_pkg::desc_t      push_desc;
  lcdseq_pkg::desc_t      head_desc;
  lcdseq_pkg::q_stat_t    q_stat;
  lcdseq_pkg::back_stat_t back_stat;
  logic                   push;

  lcdseq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .q_full_i    (q_stat.full),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  lcdseq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (back_stat.pop),
    .head_o      (head_desc),
    .stat_o      (q_stat)
  );

  lcdseq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_desc),
    .head_valid_i (!q_stat.empty),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .link_byte_o  (link_byte_o),
    .is_data_o    (is_data_o),
    .last_o       (last_o),
    .stat_o       (back_stat)
  );

  // Queue never reports full and empty together
  `LCDSEQ_ASSERT(a_q_full_empty, clk_i, rst_ni, !(q_stat.full && q_stat.empty))
  // A job leaves the queue exactly when its last byte goes out
  `LCDSEQ_ASSERT(a_pop_on_last, clk_i, rst_ni,
                 back_stat.pop == (back_stat.emit && back_stat.last))
  // Display data bytes are always single-byte items
  `LCDSEQ_ASSERT(a_data_is_last, clk_i, rst_ni, !(out_valid_o && is_data_o && !last_o))
  // A byte that is not last moves the counter off zero
  `LCDSEQ_ASSERT_NEXT(a_idx_advance, clk_i, rst_ni,
                      back_stat.emit && !back_stat.last, back_stat.idx != '0)

endmodule

// ===== tb/lcd_spi_command_sequencer_tb.sv =====
// Self-checking testbench for the LCD SPI command sequencer.
// Depends on lcdseq_pkg and the lcd_spi_command_sequencer top level only.
module lcd_spi_command_sequencer_tb;

  // Codes the block must ignore
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 200;

  // One stimulus row; typed rows carry their expected bytes
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       data;
  } step_row_t;

  localparam int NROWS = 23;
  localparam step_row_t DIR_ROWS [NROWS] = '{
    '{lcdseq_pkg::OP_BEGIN,    8'h00, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_BEGIN,    8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_BEGIN,    8'h01, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_PIXEL,    8'h00, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00, 1'b1},
    '{lcdseq_pkg::OP_PIXEL,    8'hFF, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00, 1'b1},
    '{lcdseq_pkg::OP_CONTRAST, 8'h00, 1'b1, 2'd2, 8'h81, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_CONTRAST, 8'hFF, 1'b1, 2'd2, 8'h81, 8'hFF, 8'h00, 1'b0},
    // already awake after reset: nothing goes out
    '{lcdseq_pkg::OP_POWER,    8'h01, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_POWER,    8'h00, 1'b1, 2'd2, 8'hAE, 8'hA5, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_POWER,    8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_INVERSE,  8'h01, 1'b1, 2'd2, 8'hA7, 8'hAF, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_POWER,    8'h00, 1'b1, 2'd2, 8'hAE, 8'hA5, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_POWER,    8'h00, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_POWER,    8'h02, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_INVERSE,  8'h00, 1'b1, 2'd2, 8'hA4, 8'hAF, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_INVERSE,  8'h80, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_ROW,      8'h00, 1'b1, 2'd3, 8'hB0, 8'h10, 8'h04, 1'b0},
    '{lcdseq_pkg::OP_ROW,      8'h0F, 1'b1, 2'd3, 8'hBF, 8'h10, 8'h04, 1'b0},
    // page above 15 keeps its low nibble
    '{lcdseq_pkg::OP_ROW,      8'hFF, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_ROW,      8'hA5, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{OP_SPARE_6,              8'hFF, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{OP_SPARE_7,              8'h00, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0},
    '{lcdseq_pkg::OP_PIXEL,    8'h55, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0}
  };

  // Random phases: config, idling, stalls and length
  localparam int NPHASES = 6;
  localparam int PRESSURE_PHASE = 4;
  localparam int PAUSE_PHASE = 3;
  localparam int RANDOM_CFG_PHASE = 5;
  localparam int PH_CONTRAST [NPHASES] = '{0, 255, 8'hC3, 15, 1, 0};
  localparam int PH_VARIANT  [NPHASES] = '{1, 0, 1, 0, 1, 0};
  localparam int PH_SEND     [NPHASES] = '{0, 87, 0, 32, 0, 32};
  localparam int PH_STALL    [NPHASES] = '{0, 0, 87, 32, 0, 32};
  localparam int PH_ITEMS    [NPHASES] = '{50, 50, 60, 60, 40, 60};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [2:0] operation_i = 3'd0;
  logic [7:0] value_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] link_byte_o;
  logic       is_data_o;
  logic       last_o;

  lcd_spi_command_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .link_byte_o (link_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

  // Shadow of the block's registers and state
  logic [7:0] contrast_m = lcdseq_pkg::CONTRAST_RESET;
  logic       variant_m = 1'b0;
  logic       awake_m = 1'b1;
  logic       inverse_m = 1'b0;

  lcdseq_pkg::byte_t pending_bytes [$];
  lcdseq_pkg::byte_t burst_q [$];
  lcdseq_pkg::byte_t entry;
  lcdseq_pkg::byte_t want;
  step_row_t         tag_row = '0;

  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned begins_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, pending_bytes.size());
      $display("lcd_spi_command_sequencer_tb failed");
      $finish;
    end
  end

  function automatic void add_byte(input logic [7:0] b, input logic data);
    lcdseq_pkg::byte_t e;
    e.link_byte = b;
    e.is_data   = data;
    e.last      = 1'b0;
    burst_q.push_back(e);
  endfunction

  function automatic logic [7:0] video_byte(input logic inv);
    return inv ? lcdseq_pkg::CMD_VIDEO_INV : lcdseq_pkg::CMD_VIDEO_NORM;
  endfunction

  // Link bytes one item causes; updates the shadow state
  function automatic void sequence_bytes(input logic [2:0] op, input logic [7:0] val);
    logic              flag;
    lcdseq_pkg::byte_t tail;
    flag = (val != 8'h00);
    burst_q.delete();
    case (op)
      lcdseq_pkg::OP_BEGIN: begin
        add_byte(lcdseq_pkg::CMD_SYS_RESET, 1'b0);
        add_byte(lcdseq_pkg::CMD_POWER_CTRL, 1'b0);
        add_byte(lcdseq_pkg::CMD_VOLUME, 1'b0);
        add_byte(contrast_m, 1'b0);
        add_byte(lcdseq_pkg::CMD_BIAS, 1'b0);
        add_byte(variant_m ? lcdseq_pkg::CMD_SEG_NORMAL : lcdseq_pkg::CMD_SEG_REVERSE,
                 1'b0);
        add_byte(variant_m ? lcdseq_pkg::CMD_COM_REVERSE : lcdseq_pkg::CMD_COM_NORMAL,
                 1'b0);
        add_byte(video_byte(flag), 1'b0);
        add_byte(lcdseq_pkg::CMD_DISPLAY_ON, 1'b0);
      end
      lcdseq_pkg::OP_INVERSE: begin
        inverse_m = flag;
        add_byte(video_byte(inverse_m), 1'b0);
        add_byte(lcdseq_pkg::CMD_DISPLAY_ON, 1'b0);
      end
      lcdseq_pkg::OP_CONTRAST: begin
        add_byte(lcdseq_pkg::CMD_VOLUME, 1'b0);
        add_byte(val, 1'b0);
      end
      lcdseq_pkg::OP_POWER: begin
        if (awake_m != flag) begin
          awake_m = flag;
          if (flag) begin
            add_byte(video_byte(inverse_m), 1'b0);
            add_byte(lcdseq_pkg::CMD_DISPLAY_ON, 1'b0);
          end else begin
            add_byte(lcdseq_pkg::CMD_DISPLAY_OFF, 1'b0);
            add_byte(lcdseq_pkg::CMD_ALL_ON, 1'b0);
          end
        end
      end
      lcdseq_pkg::OP_ROW: begin
        add_byte(lcdseq_pkg::CMD_PAGE_BASE | {4'h0, val[3:0]}, 1'b0);
        add_byte(lcdseq_pkg::CMD_COL_HIGH, 1'b0);
        if (!variant_m) add_byte(lcdseq_pkg::CMD_COL_LOW, 1'b0);
      end
      lcdseq_pkg::OP_PIXEL: begin
        add_byte(val, 1'b1);
      end
      default: begin
      end
    endcase
    if (burst_q.size() != 0) begin
      tail = burst_q.pop_back();
      tail.last = 1'b1;
      burst_q.push_back(tail);
    end
  endfunction

  // Input side: predict on every accepted item, then track config writes
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      sequence_bytes(operation_i, value_i);
      items_taken++;
      if (operation_i == lcdseq_pkg::OP_BEGIN) begins_taken++;
      if (tag_row.typed) begin
        for (int k = 0; k < int'(tag_row.n); k++) begin
          entry.link_byte = (k == 0) ? tag_row.b0 : (k == 1) ? tag_row.b1 : tag_row.b2;
          entry.is_data   = tag_row.data;
          entry.last      = (k == int'(tag_row.n) - 1);
          pending_bytes.push_back(entry);
        end
      end else begin
        foreach (burst_q[k]) pending_bytes.push_back(burst_q[k]);
      end
    end
    if (rst_ni && cfg_we_i) begin
      if (cfg_index_i == lcdseq_pkg::CFG_STARTUP_CONTRAST) contrast_m = cfg_data_i;
      else variant_m = cfg_data_i[0];
    end
  end

  // Output side: compare each link byte with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_seen++;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte: expected none, got %h/%b/%b", $time,
                 link_byte_o, is_data_o, last_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (link_byte_o !== want.link_byte) begin
          $display("%0t: link_byte: expected %h, got %h", $time, want.link_byte, link_byte_o);
          errors++;
        end
        if (is_data_o !== want.is_data) begin
          $display("%0t: is_data: expected %b, got %b", $time, want.is_data, is_data_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last: expected %b, got %b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item, idling first at random; returns at the accepting edge
  task automatic push_row(input step_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= row.op;
    value_i     <= row.value;
    tag_row     <= row;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every expected byte has come out
  task automatic drain(input int unsigned pad);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_panel(input logic [7:0] contrast, input logic variant);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= lcdseq_pkg::CFG_STARTUP_CONTRAST;
    cfg_data_i  <= contrast;
    @(posedge clk_i);
    cfg_index_i <= lcdseq_pkg::CFG_PANEL_VARIANT;
    cfg_data_i  <= {7'($urandom_range(127)), variant};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly valid operations, pixels weighted up, a few spare codes
  function automatic step_row_t random_row();
    step_row_t   row;
    int unsigned pick;
    row  = '0;
    pick = $urandom_range(99);
    if (pick < 8) row.op = lcdseq_pkg::OP_BEGIN;
    else if (pick < 18) row.op = lcdseq_pkg::OP_INVERSE;
    else if (pick < 28) row.op = lcdseq_pkg::OP_CONTRAST;
    else if (pick < 43) row.op = lcdseq_pkg::OP_POWER;
    else if (pick < 58) row.op = lcdseq_pkg::OP_ROW;
    else if (pick < 93) row.op = lcdseq_pkg::OP_PIXEL;
    else row.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
    row.value = 8'($urandom_range(255));
    // flags: zero half the time so state toggles often
    if ((row.op == lcdseq_pkg::OP_BEGIN || row.op == lcdseq_pkg::OP_INVERSE ||
         row.op == lcdseq_pkg::OP_POWER) && $urandom_range(1)) row.value = 8'h00;
    return row;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset configuration
    for (int i = 0; i < NROWS; i++) push_row(DIR_ROWS[i]);
    drain(TAIL_CYCLES);

    for (int p = 0; p < NPHASES; p++) begin
      send_idle_pct = int'(unsigned'(PH_SEND[p]));
      stall_pct <= int'(unsigned'(PH_STALL[p]));
      if (p == RANDOM_CFG_PHASE) begin
        write_panel(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        write_panel(8'(PH_CONTRAST[p]), 1'(PH_VARIANT[p]));
      end
      if (p == PRESSURE_PHASE) hold_req <= hold_req + 1;
      for (int k = 0; k < PH_ITEMS[p]; k++) begin
        if (p == PAUSE_PHASE && k == PH_ITEMS[p] / 2) drain(0);
        push_row(random_row());
      end
      drain(TAIL_CYCLES);
    end

    if (pending_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
      errors++;
    end
    $display("Covered %0d items (%0d begin sequences), %0d link bytes checked,",
             items_taken, begins_taken, bytes_seen);
    $display("over %0d panel settings with idle, stall and hold-off phases; %0d errors.",
             NPHASES + 1, errors);
    if (errors == 0) begin
      $display("lcd_spi_command_sequencer_tb passed");
    end else begin
      $display("lcd_spi_command_sequencer_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/lcdseq_pkg.sv
hdl/lcdseq_front.sv
hdl/lcdseq_fifo.sv
hdl/lcdseq_back.sv
hdl/lcd_spi_command_sequencer.sv
tb/lcd_spi_command_sequencer_tb.sv
